// ===== rtl/lsps_pkg.sv =====
`timescale 1ns / 1ps

package lsps_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int CFG_IDX_W       = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P    = 3'd0,
        CFG_GAIN_I    = 3'd1,
        CFG_GAIN_D    = 3'd2,
        CFG_MAX_SPEED = 3'd3,
        CFG_MIN_SPEED = 3'd4,
        CFG_LEFT_TRIM = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0] gain_p;
        logic [7:0] gain_i;
        logic [7:0] gain_d;
        logic [7:0] max_speed;
        logic [7:0] min_speed;
        logic [7:0] left_trim;
    } cfg_t;

    // One classified sensor beat, handed from the front end to the control engine.
    typedef struct packed {
        logic              lost;
        logic signed [3:0] pos;
        logic              left_rev;
        logic              right_rev;
    } cmd_t;

    typedef struct packed {
        logic              hit;
        logic signed [3:0] pos;
    } dec_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_MULP,
        BK_DIVP,
        BK_MULI,
        BK_DIVI,
        BK_MULD,
        BK_DIVD,
        BK_SUM,
        BK_STEPA,
        BK_STEPB,
        BK_OUT
    } bk_state_t;

    localparam logic [7:0]         LOST_PATTERN    = 8'hFF;
    localparam logic signed [15:0] LOST_L_LEFT     = 16'sd150;
    localparam logic signed [15:0] LOST_L_RIGHT    = 16'sd185;
    localparam logic signed [15:0] LOST_R_LEFT     = 16'sd180;
    localparam logic signed [15:0] LOST_R_RIGHT    = 16'sd155;
    localparam logic signed [9:0]  STEP_BIAS       = 10'sd20;
    localparam logic signed [15:0] DUTY_BIAS       = 16'sd15;
    // x / 10 for x up to 43689 is (x * 52429) >> 19.
    localparam logic signed [16:0] DIV10_RECIP     = 17'sd52429;
    localparam int                 DIV10_SHIFT     = 19;

    function automatic dec_t decode_pattern(input logic [7:0] s);
        dec_t d;
        d.hit = 1'b1;
        case (s)
            8'hFE:        d.pos = -4'sd7;
            8'hF8, 8'hFC: d.pos = -4'sd6;
            8'hFD:        d.pos = -4'sd5;
            8'hF1, 8'hF9: d.pos = -4'sd4;
            8'hFB:        d.pos = -4'sd3;
            8'hE3, 8'hF3: d.pos = -4'sd2;
            8'hF7:        d.pos = -4'sd1;
            8'hE7:        d.pos = 4'sd0;
            8'hEF:        d.pos = 4'sd1;
            8'hC7, 8'hCF: d.pos = 4'sd2;
            8'hDF:        d.pos = 4'sd3;
            8'h8F, 8'h9F: d.pos = 4'sd4;
            8'hBF:        d.pos = 4'sd5;
            8'h1F, 8'h3F: d.pos = 4'sd6;
            8'h7F:        d.pos = 4'sd7;
            default:
            begin
                d.hit = 1'b0;
                d.pos = 4'sd0;
            end
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/line_sensor_pid_steering.sv =====
`timescale 1ns / 1ps
// Flow: a control beat is popped in BK_IDLE and steps through the multiply, divide, sum
// and step states to BK_OUT; a lost-line beat goes from BK_IDLE straight to BK_OUT.
// The engine works on one beat at a time, using the shared 17x17 multiplier that it steps
// through eight times per control beat; BK_OUT holds while the result is full and not popped.
// Reset: rst_n clears position, directions, integral, previous error and the queues, and
// loads the register defaults; no clearing pass follows.
module line_sensor_pid_steering #(
    parameter int QUEUE_DEPTH = lsps_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [7:0]                        sensor_bits,
    output logic                              empty,
    input  logic                              pop,
    output logic signed [15:0]                left_duty,
    output logic signed [15:0]                right_duty,
    output logic                              left_reverse,
    output logic                              right_reverse,
    output logic signed [3:0]                 line_position,
    output logic                              line_lost,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lsps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [7:0]                        cfg_data
);
    import lsps_pkg::*;

    cfg_t cfg_reg;
    cmd_t front_cmd, q_rdata;
    logic accept, q_empty, q_pop;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p    <= 8'd10;
            cfg_reg.gain_i    <= 8'd0;
            cfg_reg.gain_d    <= 8'd5;
            cfg_reg.max_speed <= 8'd255;
            cfg_reg.min_speed <= 8'd0;
            cfg_reg.left_trim <= 8'd5;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_GAIN_P:    cfg_reg.gain_p    <= cfg_data;
                CFG_GAIN_I:    cfg_reg.gain_i    <= cfg_data;
                CFG_GAIN_D:    cfg_reg.gain_d    <= cfg_data;
                CFG_MAX_SPEED: cfg_reg.max_speed <= cfg_data;
                CFG_MIN_SPEED: cfg_reg.min_speed <= cfg_data;
                CFG_LEFT_TRIM: cfg_reg.left_trim <= cfg_data;
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    lsps_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .sensor_bits (sensor_bits),
        .accept      (accept),
        .cmd         (front_cmd)
    );

    lsps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_cmd),
        .full  (full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    lsps_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_rdata       (q_rdata),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .empty         (empty),
        .pop           (pop),
        .left_duty     (left_duty),
        .right_duty    (right_duty),
        .left_reverse  (left_reverse),
        .right_reverse (right_reverse),
        .line_position (line_position),
        .line_lost     (line_lost)
    );

endmodule

// ===== rtl/lsps_front.sv =====
`timescale 1ns / 1ps

module lsps_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       sensor_bits,
    input  logic             accept,
    output lsps_pkg::cmd_t   cmd
);
    import lsps_pkg::*;

    logic signed [3:0] pos_reg, pos_next;
    logic              left_rev_reg, left_rev_next;
    logic              right_rev_reg, right_rev_next;
    logic              lost;
    dec_t              dec;

    always_comb
    begin
        dec            = decode_pattern(sensor_bits);
        pos_next       = dec.hit ? dec.pos : pos_reg;
        left_rev_next  = dec.hit ? 1'b0 : left_rev_reg;
        right_rev_next = dec.hit ? 1'b0 : right_rev_reg;
        lost           = 1'b0;
        // A lost line only turns when the last known position was off center.
        if (sensor_bits == LOST_PATTERN && pos_next < 0)
        begin
            lost          = 1'b1;
            left_rev_next = 1'b1;
        end
        else if (sensor_bits == LOST_PATTERN && pos_next > 0)
        begin
            lost           = 1'b1;
            right_rev_next = 1'b1;
        end
    end

    assign cmd.lost      = lost;
    assign cmd.pos       = pos_next;
    assign cmd.left_rev  = left_rev_next;
    assign cmd.right_rev = right_rev_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 4'sd0;
            left_rev_reg  <= 1'b0;
            right_rev_reg <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg       <= pos_next;
            left_rev_reg  <= left_rev_next;
            right_rev_reg <= right_rev_next;
        end
    end

endmodule

// ===== rtl/lsps_queue.sv =====
`timescale 1ns / 1ps

module lsps_queue #(
    parameter int DEPTH = lsps_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  lsps_pkg::cmd_t   wdata,
    output logic             full,
    input  logic             pop,
    output lsps_pkg::cmd_t   rdata,
    output logic             empty
);
    import lsps_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== rtl/lsps_back.sv =====
`timescale 1ns / 1ps

module lsps_back (
    input  logic                clk,
    input  logic                rst_n,
    input  lsps_pkg::cfg_t      cfg,
    input  lsps_pkg::cmd_t      q_rdata,
    input  logic                q_empty,
    output logic                q_pop,
    output logic                empty,
    input  logic                pop,
    output logic signed [15:0]  left_duty,
    output logic signed [15:0]  right_duty,
    output logic                left_reverse,
    output logic                right_reverse,
    output logic signed [3:0]   line_position,
    output logic                line_lost
);
    import lsps_pkg::*;

    bk_state_t state_reg, state_next;

    cmd_t               cmd_reg;
    logic signed [15:0] err_reg, integral_reg, prev_err_reg;
    logic signed [15:0] t_reg, p_reg, d_reg, mv_reg, a1_reg, a2_reg;
    logic               out_valid_reg;
    logic signed [15:0] left_duty_reg, right_duty_reg;
    logic               left_rev_reg, right_rev_reg, lost_reg;
    logic signed [3:0]  pos_out_reg;

    logic signed [16:0] mul_a, mul_b;
    logic signed [33:0] prod;
    logic               out_load;

    logic signed [15:0] err_new, rate;
    logic               t_neg;
    logic [15:0]        t_mag;
    logic [12:0]        div_q;
    logic signed [15:0] div_res;
    logic signed [9:0]  diff, step, step_b;
    logic signed [15:0] top, bottom, trim;
    logic signed [15:0] l_raw, r_raw, l_duty, r_duty;

    function automatic logic signed [15:0] clamp_duty(
        input logic signed [15:0] v,
        input logic signed [15:0] lo,
        input logic signed [15:0] hi
    );
        logic signed [15:0] r;
        r = v;
        if (r < lo)
        begin
            r = lo;
        end
        if (r > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

    assign err_new = -{{12{q_rdata.pos[3]}}, q_rdata.pos};
    assign rate    = err_reg - prev_err_reg;

    // Signed divide by ten, truncating toward zero, on the shared multiplier.
    assign t_neg   = t_reg[15];
    assign t_mag   = t_neg ? 16'(-t_reg) : 16'(t_reg);
    assign div_q   = prod[DIV10_SHIFT+12:DIV10_SHIFT];
    assign div_res = t_neg ? -$signed({3'b000, div_q}) : $signed({3'b000, div_q});

    assign prod = mul_a * mul_b;

    // Step is (max - min) / 8 truncated toward zero.
    assign diff   = $signed({2'b00, cfg.max_speed}) - $signed({2'b00, cfg.min_speed});
    assign step   = (diff + (diff[9] ? 10'sd7 : 10'sd0)) >>> 3;
    assign step_b = step - STEP_BIAS;

    assign top    = $signed({8'h00, cfg.max_speed}) + 16'sd1;
    assign bottom = $signed({8'h00, cfg.min_speed});
    assign trim   = $signed({8'h00, cfg.left_trim});

    always_comb
    begin
        l_raw = top - trim;
        r_raw = top;
        if (mv_reg > 0)
        begin
            r_raw = top - a2_reg;
            l_raw = top - a1_reg - DUTY_BIAS - trim;
        end
        else if (mv_reg < 0)
        begin
            l_raw = top + a2_reg;
            r_raw = top + a1_reg - DUTY_BIAS;
        end

        if (cmd_reg.lost)
        begin
            l_duty = (cmd_reg.pos < 0) ? LOST_L_LEFT : LOST_R_LEFT;
            r_duty = (cmd_reg.pos < 0) ? LOST_L_RIGHT : LOST_R_RIGHT;
        end
        else if (mv_reg == 0)
        begin
            l_duty = l_raw;
            r_duty = r_raw;
        end
        else
        begin
            l_duty = clamp_duty(l_raw, bottom, top);
            r_duty = clamp_duty(r_raw, bottom, top);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = q_rdata.lost ? BK_OUT : BK_MULP;
                end
            end
            BK_MULP:  state_next = BK_DIVP;
            BK_DIVP:  state_next = BK_MULI;
            BK_MULI:  state_next = BK_DIVI;
            BK_DIVI:  state_next = BK_MULD;
            BK_MULD:  state_next = BK_DIVD;
            BK_DIVD:  state_next = BK_SUM;
            BK_SUM:   state_next = BK_STEPA;
            BK_STEPA: state_next = BK_STEPB;
            BK_STEPB: state_next = BK_OUT;
            BK_OUT:
            begin
                if (!out_valid_reg || pop)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:  state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        mul_a    = 17'sd0;
        mul_b    = 17'sd0;
        q_pop    = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                q_pop = !q_empty;
            end
            BK_MULP:
            begin
                mul_a = 17'(err_reg);
                mul_b = $signed({9'h000, cfg.gain_p});
            end
            BK_MULI:
            begin
                mul_a = 17'(integral_reg);
                mul_b = $signed({9'h000, cfg.gain_i});
            end
            BK_MULD:
            begin
                mul_a = 17'(rate);
                mul_b = $signed({9'h000, cfg.gain_d});
            end
            BK_DIVP, BK_DIVI, BK_DIVD:
            begin
                mul_a = $signed({1'b0, t_mag});
                mul_b = DIV10_RECIP;
            end
            BK_STEPA:
            begin
                mul_a = 17'(step);
                mul_b = 17'(mv_reg);
            end
            BK_STEPB:
            begin
                mul_a = 17'(step_b);
                mul_b = 17'(mv_reg);
            end
            BK_OUT:
            begin
                out_load = !out_valid_reg || pop;
            end
            default:
            begin
                mul_a = 17'sd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            integral_reg  <= 16'sd0;
            prev_err_reg  <= 16'sd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop && !q_rdata.lost)
            begin
                integral_reg <= integral_reg + err_new;
            end
            else if (state_reg == BK_DIVI)
            begin
                integral_reg <= div_res;
            end
            if (state_reg == BK_DIVD)
            begin
                prev_err_reg <= err_reg;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_rdata;
            err_reg <= err_new;
        end
        if (state_reg == BK_MULP || state_reg == BK_MULI || state_reg == BK_MULD)
        begin
            t_reg <= prod[15:0];
        end
        if (state_reg == BK_DIVP)
        begin
            p_reg <= div_res;
        end
        if (state_reg == BK_DIVD)
        begin
            d_reg <= div_res;
        end
        if (state_reg == BK_SUM)
        begin
            mv_reg <= p_reg + integral_reg + d_reg;
        end
        if (state_reg == BK_STEPA)
        begin
            a1_reg <= prod[15:0];
        end
        if (state_reg == BK_STEPB)
        begin
            a2_reg <= prod[15:0];
        end
        if (out_load)
        begin
            left_duty_reg  <= l_duty;
            right_duty_reg <= r_duty;
            left_rev_reg   <= cmd_reg.left_rev;
            right_rev_reg  <= cmd_reg.right_rev;
            pos_out_reg    <= cmd_reg.pos;
            lost_reg       <= cmd_reg.lost;
        end
    end

    assign empty         = !out_valid_reg;
    assign left_duty     = left_duty_reg;
    assign right_duty    = right_duty_reg;
    assign left_reverse  = left_rev_reg;
    assign right_reverse = right_rev_reg;
    assign line_position = pos_out_reg;
    assign line_lost     = lost_reg;

endmodule

// ===== tb/tb_line_sensor_pid_steering.sv =====
`timescale 1ns / 1ps

module tb_line_sensor_pid_steering;

    import lsps_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int BEATS_PER_PHASE = 148;
    localparam int NUM_PHASES = 10;

    localparam logic [7:0] LINE_PATTERNS [21] = '{
        8'hFE, 8'hF8, 8'hFC, 8'hFD, 8'hF1, 8'hF9, 8'hFB, 8'hE3, 8'hF3, 8'hF7, 8'hE7,
        8'hEF, 8'hC7, 8'hCF, 8'hDF, 8'h8F, 8'h9F, 8'hBF, 8'h1F, 8'h3F, 8'h7F
    };

    localparam logic [7:0] OPENING_BEATS [27] = '{
        8'hE7, 8'hFF, 8'h00, 8'hFE, 8'hFF, 8'hFF, 8'hF8, 8'hFC, 8'hFD, 8'hF1, 8'hF9,
        8'hFB, 8'hE3, 8'hF3, 8'hF7, 8'hEF, 8'hC7, 8'hCF, 8'hDF, 8'h8F, 8'h9F, 8'hBF,
        8'h1F, 8'h3F, 8'h7F, 8'hFF, 8'h55
    };

    typedef struct packed {
        logic signed [15:0] ldut;
        logic signed [15:0] rdut;
        logic               lrev;
        logic               rrev;
        logic signed [3:0]  pos;
        logic               lost;
    } steer_t;

    class steering_predictor;
        int kp, ki, kd, duty_max, duty_min, trim_l;
        int line_pos, integ, last_err;
        bit left_rev, right_rev;
        steer_t steer_due[$];
        int errors;

        function new();
            kp = 10;
            ki = 0;
            kd = 5;
            duty_max = 255;
            duty_min = 0;
            trim_l = 5;
            line_pos = 0;
            integ = 0;
            last_err = 0;
            left_rev = 0;
            right_rev = 0;
            errors = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [7:0] v);
            case (idx)
                CFG_GAIN_P:    kp = v;
                CFG_GAIN_I:    ki = v;
                CFG_GAIN_D:    kd = v;
                CFG_MAX_SPEED: duty_max = v;
                CFG_MIN_SPEED: duty_min = v;
                CFG_LEFT_TRIM: trim_l = v;
                default:       ;
            endcase
        endfunction

        function int wrap16(int x);
            shortint t;
            t = shortint'(x);
            return t;
        endfunction

        function int clamp(int v, int lo, int hi);
            if (v < lo)
                v = lo;
            if (v > hi)
                v = hi;
            return v;
        endfunction

        function bit lookup_line(logic [7:0] s, output int pos);
            pos = 0;
            case (s)
                8'hFE:        pos = -7;
                8'hF8, 8'hFC: pos = -6;
                8'hFD:        pos = -5;
                8'hF1, 8'hF9: pos = -4;
                8'hFB:        pos = -3;
                8'hE3, 8'hF3: pos = -2;
                8'hF7:        pos = -1;
                8'hE7:        pos = 0;
                8'hEF:        pos = 1;
                8'hC7, 8'hCF: pos = 2;
                8'hDF:        pos = 3;
                8'h8F, 8'h9F: pos = 4;
                8'hBF:        pos = 5;
                8'h1F, 8'h3F: pos = 6;
                8'h7F:        pos = 7;
                default:      return 0;
            endcase
            return 1;
        endfunction

        function void take_pattern(logic [7:0] s);
            int seen, top, bottom, stp, err, p, rate, d, mv, ld, rd;
            steer_t e;
            e.lost = 0;
            if (lookup_line(s, seen))
            begin
                line_pos = seen;
                left_rev = 0;
                right_rev = 0;
            end
            if (s == LOST_PATTERN && line_pos < 0)
            begin
                ld = LOST_L_LEFT;
                rd = LOST_L_RIGHT;
                left_rev = 1;
                e.lost = 1;
            end
            else if (s == LOST_PATTERN && line_pos > 0)
            begin
                ld = LOST_R_LEFT;
                rd = LOST_R_RIGHT;
                right_rev = 1;
                e.lost = 1;
            end
            else
            begin
                top = duty_max + 1;
                bottom = duty_min;
                stp = (duty_max - duty_min) / 8;
                err = -line_pos;
                p = wrap16(kp * err) / 10;
                // The integral is rescaled in place every step, so it decays or grows unless ki is 10.
                integ = wrap16(integ + err);
                integ = wrap16(integ * ki) / 10;
                rate = wrap16(err - last_err);
                d = wrap16(rate * kd) / 10;
                last_err = err;
                mv = wrap16(p + integ + d);
                if (mv == 0)
                begin
                    ld = wrap16(top - trim_l);
                    rd = top;
                end
                else if (mv > 0)
                begin
                    rd = wrap16(top - wrap16((stp - STEP_BIAS) * mv));
                    ld = wrap16(top - wrap16(stp * mv) - DUTY_BIAS - trim_l);
                    ld = clamp(ld, bottom, top);
                    rd = clamp(rd, bottom, top);
                end
                else
                begin
                    ld = wrap16(top + wrap16((stp - STEP_BIAS) * mv));
                    rd = wrap16(top + wrap16(wrap16(stp * mv) - DUTY_BIAS));
                    ld = clamp(ld, bottom, top);
                    rd = clamp(rd, bottom, top);
                end
            end
            e.ldut = ld[15:0];
            e.rdut = rd[15:0];
            e.lrev = left_rev;
            e.rrev = right_rev;
            e.pos = line_pos[3:0];
            steer_due.push_back(e);
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task check_steer(steer_t got);
            steer_t want;
            if (steer_due.size() == 0)
            begin
                report("result beat with no sensor beat pending");
                return;
            end
            want = steer_due.pop_front();
            if (got.ldut !== want.ldut)
                report($sformatf("left_duty got %0d want %0d", got.ldut, want.ldut));
            if (got.rdut !== want.rdut)
                report($sformatf("right_duty got %0d want %0d", got.rdut, want.rdut));
            if (got.lrev !== want.lrev)
                report($sformatf("left_reverse got %0b want %0b", got.lrev, want.lrev));
            if (got.rrev !== want.rrev)
                report($sformatf("right_reverse got %0b want %0b", got.rrev, want.rrev));
            if (got.pos !== want.pos)
                report($sformatf("line_position got %0d want %0d", got.pos, want.pos));
            if (got.lost !== want.lost)
                report($sformatf("line_lost got %0b want %0b", got.lost, want.lost));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    logic [7:0] sensor_bits;
    logic empty;
    logic pop;
    logic signed [15:0] left_duty;
    logic signed [15:0] right_duty;
    logic left_reverse;
    logic right_reverse;
    logic signed [3:0] line_position;
    logic line_lost;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0] cfg_data;

    steering_predictor steer_model = new();
    bit no_idle;
    bit rx_hold_req;
    int quiet_cycles;

    line_sensor_pid_steering dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .sensor_bits   (sensor_bits),
        .empty         (empty),
        .pop           (pop),
        .left_duty     (left_duty),
        .right_duty    (right_duty),
        .left_reverse  (left_reverse),
        .right_reverse (right_reverse),
        .line_position (line_position),
        .line_lost     (line_lost),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Mostly listed patterns and loss beats, so the lost-line turns and the PID
    // history get exercised; the rest is arbitrary noise.
    function automatic logic [7:0] pick_pattern();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return LINE_PATTERNS[$urandom_range(0, 20)];
        if (r < 75)
            return LOST_PATTERN;
        return 8'($urandom_range(0, 255));
    endfunction

    // Result side: pop is decided at the falling edge, the beat is taken at the rising edge.
    initial
    begin : result_side
        int hold;
        int gap;
        steer_t got;
        hold = 0;
        gap = 0;
        pop = 0;
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                got.ldut = left_duty;
                got.rdut = right_duty;
                got.lrev = left_reverse;
                got.rrev = right_reverse;
                got.pos = line_position;
                got.lost = line_lost;
                steer_model.check_steer(got);
                gap = pick_gap();
            end
            @(negedge clk);
            if (rx_hold_req)
            begin
                hold = RX_HOLD_CYCLES;
                rx_hold_req = 0;
            end
            if (hold > 0)
            begin
                pop = 0;
                hold--;
            end
            else if (gap > 0)
            begin
                pop = 0;
                gap--;
            end
            else
                pop = 1;
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_beat(input logic [7:0] s);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            push = 0;
            repeat (gap) @(negedge clk);
        end
        push = 1;
        sensor_bits = s;
        do
            @(posedge clk);
        while (full);
        steer_model.take_pattern(s);
    endtask

    task automatic end_burst();
        @(negedge clk);
        push = 0;
    endtask

    task automatic drain();
        while (steer_model.steer_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [7:0] v);
        @(negedge clk);
        cfg_valid = 1;
        cfg_index = idx;
        cfg_data = v;
        do
            @(posedge clk);
        while (!cfg_ready);
        steer_model.set_reg(idx, v);
        @(negedge clk);
        cfg_valid = 0;
    endtask

    task automatic load_regs(input logic [7:0] p, input logic [7:0] i, input logic [7:0] d,
                             input logic [7:0] hi, input logic [7:0] lo, input logic [7:0] t);
        write_reg(CFG_GAIN_P, p);
        write_reg(CFG_GAIN_I, i);
        write_reg(CFG_GAIN_D, d);
        write_reg(CFG_MAX_SPEED, hi);
        write_reg(CFG_MIN_SPEED, lo);
        write_reg(CFG_LEFT_TRIM, t);
    endtask

    initial
    begin : sensor_side
        quiet_cycles = 0;
        no_idle = 0;
        rx_hold_req = 0;
        rst_n = 0;
        push = 0;
        sensor_bits = 8'h00;
        cfg_valid = 0;
        cfg_index = CFG_GAIN_P;
        cfg_data = 8'h00;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        foreach (OPENING_BEATS[k])
            send_beat(OPENING_BEATS[k]);
        end_burst();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            // The sender waits here until every result is back, so the block is idle.
            drain();
            repeat (2) @(negedge clk);
            case (ph)
                0: load_regs(8'd10, 8'd0, 8'd5, 8'd255, 8'd0, 8'd5);
                1: load_regs(8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255);
                2: load_regs(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
                3: load_regs(8'd0, 8'd0, 8'd0, 8'd100, 8'd200, 8'd0);
                4: load_regs(8'd40, 8'd12, 8'd30, 8'd200, 8'd40, 8'd5);
                5: load_regs(8'd10, 8'd10, 8'd10, 8'd255, 8'd255, 8'd0);
                default:
                    load_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 15)),
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            endcase
            no_idle = (ph == 4);
            if (ph == 2 || ph == 7)
                rx_hold_req = 1;
            repeat (BEATS_PER_PHASE)
                send_beat(pick_pattern());
            end_burst();
        end

        no_idle = 0;
        drain();
        repeat (20) @(posedge clk);
        if (steer_model.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
